// ===== hw/rtl/lrk_pkg.sv =====
`default_nettype none

package lrk_pkg;

    // Number format
    localparam int VW = 48;
    localparam int FB = 32;

    // Register widths and indexes
    localparam int GAIN_W = 47;
    localparam int STEP_W = 33;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = GAIN_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIGMA = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RHO   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BETA  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP  = 2'd3;

    localparam logic [GAIN_W-1:0] SIGMA_RST = GAIN_W'(64'd10 << FB);
    localparam logic [GAIN_W-1:0] RHO_RST   = GAIN_W'(64'd28 << FB);
    localparam logic [GAIN_W-1:0] BETA_RST  = GAIN_W'(((64'd16 << FB) + 64'd3) / 64'd6);
    localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(((64'd1 << FB) + 64'd500) / 64'd1000);

    localparam logic [VW-1:0] PY_RST = VW'(64'd8 << FB);
    localparam logic [VW-1:0] PX_RST = VW'(-(64'd8 << FB));
    localparam logic [VW-1:0] PZ_RST = VW'(64'd27 << FB);

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // Shared multiplier and divide-by-6 unit
    localparam int HW = VW / 2;
    localparam int ACC_W = 2 * VW;
    localparam int RND_W = ACC_W + 1;
    localparam int MUL_LAST = 4;
    localparam int DIV_W = ((VW + 1 + 3) / 4) * 4;
    localparam int DIV_LAST = DIV_W / 4 + 1;
    localparam int CNT_W = $clog2(DIV_LAST + 1);

    // Scratch memory map
    localparam int RAM_DEPTH = 16;
    localparam int RA_W = $clog2(RAM_DEPTH);
    typedef logic [RA_W-1:0] addr_t;
    localparam addr_t A_QX = 4'd12;
    localparam addr_t A_QY = 4'd13;
    localparam addr_t A_QZ = 4'd14;
    localparam addr_t A_T  = 4'd15;

    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] LAST_PC = 7'd79;

    typedef enum logic [2:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV6
    } op_t;

    typedef enum logic [2:0] {
        SRC_RAM, SRC_PX, SRC_PY, SRC_PZ, SRC_SG, SRC_RH, SRC_BT, SRC_H
    } src_t;

    typedef enum logic [1:0] {
        DST_RAM, DST_PX, DST_PY, DST_PZ
    } dst_t;

    typedef struct packed {
        op_t   op;
        logic  half;
        src_t  sa;
        addr_t aa;
        src_t  sb;
        addr_t ab;
        dst_t  dst;
        addr_t da;
        logic  last;
    } uop_t;

    typedef struct packed {
        logic start;
        logic load;
        logic clr_flag;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_sts_t;

    function automatic src_t p_src(input logic [1:0] i);
        src_t s;
        case (i)
            2'd0:    s = SRC_PX;
            2'd1:    s = SRC_PY;
            default: s = SRC_PZ;
        endcase
        return s;
    endfunction

    function automatic dst_t p_dst(input logic [1:0] i);
        dst_t s;
        case (i)
            2'd0:    s = DST_PX;
            2'd1:    s = DST_PY;
            default: s = DST_PZ;
        endcase
        return s;
    endfunction

    // Three times a small index: base of one k vector in scratch
    function automatic addr_t k_base(input logic [1:0] d);
        return ({2'b00, d} << 1) + {2'b00, d};
    endfunction

    // Step program: four derivative passes, three stage-point updates
    // and the weighted sum per axis, eight slots each.
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        logic [3:0] seg;
        logic [2:0] j;
        logic [1:0] d;
        logic [1:0] i;
        addr_t kb;
        src_t qx_s;
        src_t qy_s;
        src_t qz_s;
        seg = pc[6:3];
        j = pc[2:0];
        d = seg[2:1];
        kb = k_base(d);
        i = j[2:1];
        qx_s = (d == 2'd0) ? SRC_PX : SRC_RAM;
        qy_s = (d == 2'd0) ? SRC_PY : SRC_RAM;
        qz_s = (d == 2'd0) ? SRC_PZ : SRC_RAM;
        u = '{op: OP_NOP, half: 1'b0, sa: SRC_RAM, aa: A_T, sb: SRC_RAM, ab: A_T,
              dst: DST_RAM, da: A_T, last: 1'b0};
        case (seg) inside
            4'd0, 4'd2, 4'd4, 4'd6: begin
                case (j)
                    3'd0: begin
                        u.op = OP_SUB; u.sa = qy_s; u.aa = A_QY; u.sb = qx_s; u.ab = A_QX;
                    end
                    3'd1: begin
                        u.op = OP_MUL; u.sa = SRC_SG; u.da = kb;
                    end
                    3'd2: begin
                        u.op = OP_SUB; u.sa = SRC_RH; u.sb = qz_s; u.ab = A_QZ;
                    end
                    3'd3: begin
                        u.op = OP_MUL; u.sa = qx_s; u.aa = A_QX; u.da = kb + 4'd1;
                    end
                    3'd4: begin
                        u.op = OP_SUB; u.aa = kb + 4'd1; u.sb = qy_s; u.ab = A_QY;
                        u.da = kb + 4'd1;
                    end
                    3'd5: begin
                        u.op = OP_MUL; u.sa = qx_s; u.aa = A_QX; u.sb = qy_s; u.ab = A_QY;
                    end
                    3'd6: begin
                        u.op = OP_MUL; u.sa = SRC_BT; u.sb = qz_s; u.ab = A_QZ;
                        u.da = kb + 4'd2;
                    end
                    default: begin
                        u.op = OP_SUB; u.ab = kb + 4'd2; u.da = kb + 4'd2;
                    end
                endcase
            end
            4'd1, 4'd3, 4'd5: begin
                if (j < 3'd6) begin
                    if (!j[0]) begin
                        u.op = OP_MUL; u.half = (d != 2'd2); u.sa = SRC_H;
                        u.ab = kb + {2'b00, i};
                    end else begin
                        u.op = OP_ADD; u.sa = p_src(i); u.da = A_QX + {2'b00, i};
                    end
                end
            end
            4'd7, 4'd8, 4'd9: begin
                i = 2'(seg - 4'd7);
                case (j)
                    3'd0: begin
                        u.op = OP_ADD; u.aa = 4'd3 + {2'b00, i}; u.ab = 4'd3 + {2'b00, i};
                    end
                    3'd1: begin
                        u.op = OP_ADD; u.aa = {2'b00, i};
                    end
                    3'd2: begin
                        u.op = OP_ADD; u.aa = 4'd6 + {2'b00, i}; u.ab = 4'd6 + {2'b00, i};
                        u.da = 4'd3 + {2'b00, i};
                    end
                    3'd3: begin
                        u.op = OP_ADD; u.ab = 4'd3 + {2'b00, i};
                    end
                    3'd4: begin
                        u.op = OP_ADD; u.ab = 4'd9 + {2'b00, i};
                    end
                    3'd5: begin
                        u.op = OP_MUL; u.sa = SRC_H;
                    end
                    3'd6: begin
                        u.op = OP_DIV6;
                    end
                    default: begin
                        u.op = OP_ADD; u.sa = p_src(i); u.dst = p_dst(i);
                        u.last = (i == 2'd2);
                    end
                endcase
            end
            default: u.op = OP_NOP;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lrk_ram.sv =====
`default_nettype none

module lrk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lrk_dpath.sv =====
`default_nettype none

module lrk_dpath import lrk_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [VW-1:0]         load_x,
    input  wire logic [VW-1:0]         load_y,
    input  wire logic [VW-1:0]         load_z,
    output dp_sts_t                    sts,
    output logic [VW-1:0]              pnt_x,
    output logic [VW-1:0]              pnt_y,
    output logic [VW-1:0]              pnt_z,
    output logic                       ovf
);

    logic [GAIN_W-1:0] sigma_reg, rho_reg, beta_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VW-1:0]     px_reg, py_reg, pz_reg;
    logic              flag_reg;
    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    uop_t              uop_reg;
    logic [VW-1:0]     opa_reg, opb_reg, ma_reg, mb_reg;
    logic              na_reg, nb_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [2:0]        rem_reg, rem_next;

    logic [VW-1:0]     ram_a, ram_b, sel_a, sel_b, res;
    logic              done, sat, ram_we;
    logic [VW:0]       sum;
    logic              as_ovf;
    logic [HW-1:0]     mx, my;
    logic [VW-1:0]     prod;
    logic [ACC_W-1:0]  pp;
    logic [RND_W-1:0]  rnd, mq, lim;
    logic              mneg, mul_sat;
    logic [VW-1:0]     mul_res, div_res, as_res;
    logic [3:0]        r4;

    lrk_ram #(.WIDTH(VW), .DEPTH(RAM_DEPTH)) u_ram (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (uop_reg.da),
        .wdata   (res),
        .raddr_a (cmd.uop.aa),
        .raddr_b (cmd.uop.ab),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    function automatic logic [VW-1:0] pick(input src_t s, input logic [VW-1:0] r,
                                           input logic [VW-1:0] x, input logic [VW-1:0] y,
                                           input logic [VW-1:0] z, input logic [GAIN_W-1:0] sg,
                                           input logic [GAIN_W-1:0] rh,
                                           input logic [GAIN_W-1:0] bt,
                                           input logic [STEP_W-1:0] h);
        logic [VW-1:0] v;
        case (s)
            SRC_PX:  v = x;
            SRC_PY:  v = y;
            SRC_PZ:  v = z;
            SRC_SG:  v = VW'(sg);
            SRC_RH:  v = VW'(rh);
            SRC_BT:  v = VW'(bt);
            SRC_H:   v = VW'(h);
            default: v = r;
        endcase
        return v;
    endfunction

    always_comb begin
        sel_a = pick(cmd.uop.sa, ram_a, px_reg, py_reg, pz_reg, sigma_reg, rho_reg,
                     beta_reg, step_reg);
        sel_b = pick(cmd.uop.sb, ram_b, px_reg, py_reg, pz_reg, sigma_reg, rho_reg,
                     beta_reg, step_reg);
    end

    // add / subtract with saturation
    always_comb begin
        if (uop_reg.op == OP_SUB) begin
            sum = {opa_reg[VW-1], opa_reg} - {opb_reg[VW-1], opb_reg};
        end else begin
            sum = {opa_reg[VW-1], opa_reg} + {opb_reg[VW-1], opb_reg};
        end
        as_ovf = sum[VW] ^ sum[VW-1];
        as_res = as_ovf ? (sum[VW] ? VMIN : VMAX) : sum[VW-1:0];
    end

    // one partial product per cycle, then round and saturate
    always_comb begin
        mx = cnt_reg[1] ? ma_reg[VW-1:HW] : ma_reg[HW-1:0];
        my = cnt_reg[0] ? mb_reg[VW-1:HW] : mb_reg[HW-1:0];
        prod = VW'(mx * my);
        case (cnt_reg)
            CNT_W'(0):       pp = ACC_W'(prod);
            CNT_W'(1),
            CNT_W'(2):       pp = ACC_W'(prod) << HW;
            default:         pp = ACC_W'(prod) << VW;
        endcase
        mneg = na_reg ^ nb_reg;
        rnd = {1'b0, acc_reg} + (uop_reg.half ? (RND_W'(1) << FB) : (RND_W'(1) << (FB - 1)));
        mq = uop_reg.half ? (rnd >> (FB + 1)) : (rnd >> FB);
        lim = mneg ? RND_W'(VMIN) : RND_W'(VMAX);
        mul_sat = (mq > lim);
        if (mul_sat) begin
            mul_res = mneg ? VMIN : VMAX;
        end else begin
            mul_res = mneg ? (VW'(0) - mq[VW-1:0]) : mq[VW-1:0];
        end
    end

    // divide by 6, four quotient bits a cycle
    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int k = 0; k < 4; k++) begin
            r4 = {rem_next, dvd_next[DIV_W-1]};
            dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
            if (r4 >= 4'd6) begin
                rem_next = 3'(r4 - 4'd6);
                dvd_next[0] = 1'b1;
            end else begin
                rem_next = r4[2:0];
            end
        end
        div_res = na_reg ? (VW'(0) - dvd_reg[VW-1:0]) : dvd_reg[VW-1:0];
    end

    always_comb begin
        case (uop_reg.op)
            OP_MUL:  done = busy_reg && (cnt_reg == CNT_W'(MUL_LAST));
            OP_DIV6: done = busy_reg && (cnt_reg == CNT_W'(DIV_LAST));
            default: done = busy_reg;
        endcase
        case (uop_reg.op)
            OP_MUL: begin
                res = mul_res;
                sat = done && mul_sat;
            end
            OP_DIV6: begin
                res = div_res;
                sat = 1'b0;
            end
            default: begin
                res = as_res;
                sat = done && as_ovf;
            end
        endcase
        ram_we = done && (uop_reg.dst == DST_RAM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RST;
            rho_reg   <= RHO_RST;
            beta_reg  <= BETA_RST;
            step_reg  <= STEP_RST;
            px_reg    <= PX_RST;
            py_reg    <= PY_RST;
            pz_reg    <= PZ_RST;
            flag_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SIGMA: sigma_reg <= cfg_wdata;
                    CFG_RHO:   rho_reg   <= cfg_wdata;
                    CFG_BETA:  beta_reg  <= cfg_wdata;
                    CFG_STEP:  step_reg  <= cfg_wdata[STEP_W-1:0];
                    default:   ;
                endcase
            end
            if (cmd.load) begin
                px_reg <= load_x;
                py_reg <= load_y;
                pz_reg <= load_z;
            end else if (done) begin
                case (uop_reg.dst)
                    DST_PX:  px_reg <= res;
                    DST_PY:  py_reg <= res;
                    DST_PZ:  pz_reg <= res;
                    default: ;
                endcase
            end
            if (cmd.clr_flag) begin
                flag_reg <= 1'b0;
            end else if (sat) begin
                flag_reg <= 1'b1;
            end
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (done) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // operand and arithmetic payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            uop_reg <= cmd.uop;
            opa_reg <= sel_a;
            opb_reg <= sel_b;
            ma_reg  <= sel_a[VW-1] ? (VW'(0) - sel_a) : sel_a;
            mb_reg  <= sel_b[VW-1] ? (VW'(0) - sel_b) : sel_b;
            na_reg  <= sel_a[VW-1];
            nb_reg  <= sel_b[VW-1];
        end
        if (busy_reg && uop_reg.op == OP_MUL && cnt_reg < CNT_W'(MUL_LAST)) begin
            acc_reg <= ((cnt_reg == CNT_W'(0)) ? ACC_W'(0) : acc_reg) + pp;
        end
        if (busy_reg && uop_reg.op == OP_DIV6) begin
            if (cnt_reg == CNT_W'(0)) begin
                dvd_reg <= DIV_W'({1'b0, ma_reg} + (VW + 1)'(3));
                rem_reg <= 3'd0;
            end else if (cnt_reg < CNT_W'(DIV_LAST)) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done;
    assign pnt_x = px_reg;
    assign pnt_y = py_reg;
    assign pnt_z = pz_reg;
    assign ovf = flag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lrk_ctrl.sv =====
`default_nettype none

module lrk_ctrl import lrk_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_load,
    input  wire logic    out_free,
    input  wire dp_sts_t sts,
    output logic         s_ready,
    output dp_cmd_t      cmd,
    output logic         out_load
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;
    logic            accept;

    always_comb begin
        uop = uop_at(pc_reg);
        accept = s_valid && (state_reg == ST_IDLE);
        s_ready = (state_reg == ST_IDLE);
        state_next = state_reg;
        pc_next = pc_reg;
        cmd.start = 1'b0;
        cmd.load = 1'b0;
        cmd.clr_flag = 1'b0;
        cmd.uop = uop;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.clr_flag = 1'b1;
                    pc_next = '0;
                    if (s_load) begin
                        cmd.load = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (uop.op == OP_NOP) begin
                    pc_next = pc_reg + PC_W'(1);
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.done) begin
                    if (uop.last) begin
                        state_next = ST_DONE;
                    end else begin
                        pc_next = pc_reg + PC_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_in_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> state_reg == ST_ISSUE)
        else $error("datapath start outside issue state");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> state_reg == ST_WAIT)
        else $error("datapath done while controller not waiting");

    a_idle_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.busy)
        else $error("input ready while datapath busy");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= LAST_PC)
        else $error("program counter past end of step program");

    a_issue_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> sts.busy)
        else $error("datapath not busy after start");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lorenz_rk4_integrator_core.sv =====
`default_nettype none

// Channel   Dir  Payload (low bit up)                         Handshake
// s_        in   tdata: load_x, load_y, load_z; tuser: cmd    tvalid/tready
// m_        out  tdata: out_x, out_y, out_z; tuser: overflow  tvalid/tready
// cfg_      in   index 0 sigma, 1 rho, 2 beta, 3 step size    cfg_wr_en, no wait
//
// A load word passes from the idle state straight to the done state. An advance word's
// time is set by the shared 24x24 multiplier (28 products), the divide-by-6
// unit (4 bits a cycle) and the fetch and issue states that each of the 74
// operations of the step program passes through.
// aresetn is synchronous: the point returns to (-8, 8, 27), registers to defaults.
// A result waits in the output register while the next word is accepted;
// the block stalls only when a second result is ready and the first is not taken.

module lorenz_rk4_integrator_core import lrk_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [3*VW-1:0]       s_tdata,   // load_x, load_y, load_z
    input  wire logic [0:0]            s_tuser,   // cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [3*VW-1:0]            m_tdata,   // out_x, out_y, out_z
    output logic [0:0]                 m_tuser,   // overflow
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t       cmd;
    dp_sts_t       sts;
    logic          out_free, out_load;
    logic [VW-1:0] pnt_x, pnt_y, pnt_z;
    logic          ovf;

    logic            m_tvalid_reg;
    logic [3*VW-1:0] m_tdata_reg;
    logic            m_tuser_reg;

    // hold a finished word until the sink takes it
    assign out_free = !m_tvalid_reg || m_tready;

    lrk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_load   (s_tuser[0]),
        .out_free (out_free),
        .sts      (sts),
        .s_ready  (s_tready),
        .cmd      (cmd),
        .out_load (out_load)
    );

    lrk_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .load_x    (s_tdata[VW-1:0]),
        .load_y    (s_tdata[2*VW-1:VW]),
        .load_z    (s_tdata[3*VW-1:2*VW]),
        .sts       (sts),
        .pnt_x     (pnt_x),
        .pnt_y     (pnt_y),
        .pnt_z     (pnt_z),
        .ovf       (ovf)
    );

    // output register: advance on load, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {pnt_z, pnt_y, pnt_x};
            m_tuser_reg <= ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire
